// ===== rtl/core/mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared widths, register indexes and types for the Muskingum flow router.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int FLOW_PORT_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int TIME_W      = 32;
  localparam int WEIGHT_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUTING_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 2'd2;

  localparam logic [TIME_W-1:0]   ROUTING_TIME_RST  = 32'd6553600;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FACTOR_RST = 16'd13107;
  localparam logic [TIME_W-1:0]   TIME_STEP_RST     = 32'd65536;

  // x is limited to one half
  localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT = 16'd32768;

  // coefficient terms at a scale of 2^-32 s
  localparam int KF_SHIFT = 16;
  localparam int HD_SHIFT = 15;
  localparam int KX_W     = TIME_W + WEIGHT_W;
  localparam int HD_W     = TIME_W + HD_SHIFT;
  localparam int DEN_W    = TIME_W + KF_SHIFT + 1;

  // shared multiplier: signed operand x unsigned chunk
  localparam int CHUNK_BITS = 24;
  localparam int MULT_A_W   = TIME_W + 1;
  localparam int MULT_B_W   = CHUNK_BITS;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/muskingum_flow_router.sv =====
// ----------------------------------------------------------------------------
// muskingum_flow_router
// Muskingum routing of an inflow series through one reach, with the three
// coefficients derived on a series-start beat by a shared serial divider.
// Routed beat: three terms multiplied in NCH chunks, NCH = ceil(FLOW_BITS/24), on
//   the shared multiplier; the next beat is taken only after out_valid is loaded.
// Series-start beat: coefficients derived by the bit-serial divider, inflow passed out.
// Synchronous active-low reset clears state, coefficients and registers to
// their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module muskingum_flow_router #(
  parameter int FLOW_BITS      = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mfr_pkg::FLOW_PORT_W-1:0]  in_inflow_sample,
  input  logic                             in_series_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mfr_pkg::FLOW_PORT_W-1:0]  out_outflow_sample,
  input  logic                             cfg_we,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mfr_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int NCH       = (FLOW_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W     = NCH * CHUNK_BITS;
  localparam int P_W       = MULT_A_W + MULT_B_W + 1;
  localparam int ACC_W     = FLOW_BITS + COEF_FRAC_BITS + 4;
  localparam int QS_W      = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic [1:0] TERM_NOW      = 2'd0;
  localparam logic [1:0] TERM_PREV_IN  = 2'd1;
  localparam logic [1:0] TERM_PREV_OUT = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_KX    = 9'b000000010,
    S_SETUP = 9'b000000100,
    S_DIVGO = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_ACC   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 term_r, term_nxt;
  logic [CH_W-1:0]            chunk_r, chunk_nxt;
  logic [TIME_W-1:0]          routing_time_r, routing_time_nxt;
  logic [WEIGHT_W-1:0]        weight_factor_r, weight_factor_nxt;
  logic [TIME_W-1:0]          time_step_r, time_step_nxt;
  logic [FLOW_BITS-1:0]       inflow_r, inflow_nxt;
  logic [FLOW_BITS-1:0]       res_r, res_nxt;
  logic [FLOW_BITS-1:0]       last_in_r, last_in_nxt;
  logic [FLOW_BITS-1:0]       last_out_r, last_out_nxt;
  logic signed [COEF_BITS-1:0] coef_r [3];
  logic signed [COEF_BITS-1:0] coef_nxt [3];
  logic [DEN_W-1:0]           den_r, den_nxt;
  logic [DEN_W:0]             num_r [3];
  logic [DEN_W:0]             num_nxt [3];
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic                       prod_vld_r, prod_vld_nxt;
  logic [CH_W-1:0]            prod_chunk_r, prod_chunk_nxt;
  logic [FLOW_BITS-1:0]       out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       in_acc;
  logic                       out_free;
  logic                       mult_en;
  logic signed [MULT_A_W-1:0] mult_a;
  logic [MULT_B_W-1:0]        mult_b;
  logic signed [P_W-1:0]      mult_p;
  logic [FLOW_BITS-1:0]       flow_sel;
  logic [PAD_W-1:0]           flow_pad;
  logic [WEIGHT_W-1:0]        x_lim;
  logic [TIME_W-1:0]          dt_eff;
  logic [KX_W-1:0]            kx;
  logic [KX_W-1:0]            kf;
  logic [HD_W-1:0]            hd;
  logic signed [ACC_W-1:0]    term_val;
  logic [QS_W-1:0]            sum_q;
  logic [FLOW_BITS-1:0]       sum_sat;
  logic                       div_start;
  logic [COEF_BITS-1:0]       div_coef;
  div_stat_t                  div_stat;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---- shared multiplier operands ----
  assign x_lim  = (weight_factor_r > WEIGHT_LIMIT) ? WEIGHT_LIMIT : weight_factor_r;
  assign dt_eff = (time_step_r == '0) ? TIME_W'(1) : time_step_r;

  always_comb begin
    case (term_r)
      TERM_NOW:     flow_sel = inflow_r;
      TERM_PREV_IN: flow_sel = last_in_r;
      default:      flow_sel = last_out_r;
    endcase
  end

  assign flow_pad = PAD_W'(flow_sel);
  assign mult_en  = (state_r == S_KX) || (state_r == S_MUL);

  always_comb begin
    if (state_r == S_KX) begin
      mult_a = $signed({1'b0, routing_time_r});
      mult_b = MULT_B_W'(x_lim);
    end else begin
      mult_a = MULT_A_W'(coef_r[term_r]);
      mult_b = flow_pad[chunk_r*CHUNK_BITS +: CHUNK_BITS];
    end
  end

  mfr_mult #(
    .A_W (MULT_A_W),
    .B_W (MULT_B_W)
  ) u_mult (
    .clk (clk),
    .en  (mult_en),
    .a   (mult_a),
    .b   (mult_b),
    .p   (mult_p)
  );

  // ---- coefficient terms ----
  assign kx = mult_p[KX_W-1:0];
  assign kf = {routing_time_r, {KF_SHIFT{1'b0}}};
  assign hd = {dt_eff, {HD_SHIFT{1'b0}}};

  assign div_start = (state_r == S_DIVGO);

  mfr_div #(
    .DEN_W (DEN_W),
    .Q_W   (COEF_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[term_r]),
    .den   (den_r),
    .coef  (div_coef),
    .stat  (div_stat)
  );

  // ---- accumulate and saturate ----
  assign term_val = ACC_W'(mult_p) <<< (CHUNK_BITS * prod_chunk_r);
  assign sum_q    = acc_r[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      sum_sat = '0;
    end else if (|sum_q[QS_W-1:FLOW_BITS]) begin
      sum_sat = '1;
    end else begin
      sum_sat = sum_q[FLOW_BITS-1:0];
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt         = state_r;
    term_nxt          = term_r;
    chunk_nxt         = chunk_r;
    routing_time_nxt  = routing_time_r;
    weight_factor_nxt = weight_factor_r;
    time_step_nxt     = time_step_r;
    inflow_nxt        = inflow_r;
    res_nxt           = res_r;
    last_in_nxt       = last_in_r;
    last_out_nxt      = last_out_r;
    coef_nxt          = coef_r;
    den_nxt           = den_r;
    num_nxt           = num_r;
    acc_nxt           = acc_r;
    prod_vld_nxt      = (state_r == S_MUL);
    prod_chunk_nxt    = chunk_r;
    out_data_nxt      = out_data_r;
    out_valid_nxt     = out_valid_r && out_stall;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ROUTING_TIME:  routing_time_nxt  = cfg_wdata[TIME_W-1:0];
        CFG_WEIGHT_FACTOR: weight_factor_nxt = cfg_wdata[WEIGHT_W-1:0];
        CFG_TIME_STEP:     time_step_nxt     = cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end

    if (prod_vld_r) begin
      acc_nxt = acc_r + term_val;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          inflow_nxt = FLOW_BITS'(in_inflow_sample);
          term_nxt   = TERM_NOW;
          chunk_nxt  = '0;
          acc_nxt    = ROUND_HALF;
          if (in_series_start) begin
            res_nxt   = FLOW_BITS'(in_inflow_sample);
            state_nxt = S_KX;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_KX: begin
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        den_nxt    = DEN_W'(kf) - DEN_W'(kx) + DEN_W'(hd);
        num_nxt[0] = (DEN_W+1)'(hd) - (DEN_W+1)'(kx);
        num_nxt[1] = (DEN_W+1)'(kx) + (DEN_W+1)'(hd);
        num_nxt[2] = (DEN_W+1)'(kf) - (DEN_W+1)'(kx) - (DEN_W+1)'(hd);
        state_nxt  = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          coef_nxt[term_r] = div_coef;
          if (term_r == TERM_PREV_OUT) begin
            state_nxt = S_DONE;
          end else begin
            term_nxt  = term_r + 1'b1;
            state_nxt = S_DIVGO;
          end
        end
      end
      S_MUL: begin
        if (chunk_r == CH_W'(NCH - 1)) begin
          chunk_nxt = '0;
          if (term_r == TERM_PREV_OUT) begin
            state_nxt = S_ACC;
          end else begin
            term_nxt = term_r + 1'b1;
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_ACC: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_nxt   = sum_sat;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          last_in_nxt   = inflow_r;
          last_out_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      term_r          <= TERM_NOW;
      chunk_r         <= '0;
      routing_time_r  <= ROUTING_TIME_RST;
      weight_factor_r <= WEIGHT_FACTOR_RST;
      time_step_r     <= TIME_STEP_RST;
      last_in_r       <= '0;
      last_out_r      <= '0;
      coef_r          <= '{default: '0};
      prod_vld_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      term_r          <= term_nxt;
      chunk_r         <= chunk_nxt;
      routing_time_r  <= routing_time_nxt;
      weight_factor_r <= weight_factor_nxt;
      time_step_r     <= time_step_nxt;
      last_in_r       <= last_in_nxt;
      last_out_r      <= last_out_nxt;
      coef_r          <= coef_nxt;
      prod_vld_r      <= prod_vld_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inflow_r     <= inflow_nxt;
    res_r        <= res_nxt;
    den_r        <= den_nxt;
    num_r        <= num_nxt;
    acc_r        <= acc_nxt;
    prod_chunk_r <= prod_chunk_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_outflow_sample = FLOW_PORT_W'(out_data_r);

  // ---- checks ----
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide state");

  a_prod_in_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r |-> (state_r == S_MUL || state_r == S_ACC))
    else $error("product arrived outside the multiply phase");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not held off after an accepted beat");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished result not presented");

endmodule

// ===== rtl/core/mfr_mult.sv =====
// ----------------------------------------------------------------------------
// mfr_mult
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mfr_mult #(
  parameter int A_W = 33,
  parameter int B_W = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_W-1:0]    a,
  input  logic        [B_W-1:0]    b,
  output logic signed [A_W+B_W:0]  p
);
  logic signed [A_W+B_W:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * $signed({1'b0, b});
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/mfr_div.sv =====
// ----------------------------------------------------------------------------
// mfr_div
// Restoring divider, one quotient bit per cycle, for the routing coefficients.
// Returns |num|/den rounded half away from zero, sign reapplied.
// ----------------------------------------------------------------------------
module mfr_div #(
  parameter int DEN_W = 49,
  parameter int Q_W   = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DEN_W:0]            num,
  input  logic [DEN_W-1:0]          den,
  output logic [Q_W-1:0]            coef,
  output mfr_pkg::div_stat_t        stat
);
  import mfr_pkg::*;

  localparam int R_W   = DEN_W + 1;
  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [R_W-1:0]   den_r, den_nxt;
  logic [R_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;

  logic [R_W-1:0]   mag;
  logic             ge;
  logic [R_W-1:0]   diff;
  logic [Q_W:0]     rnd;
  logic [Q_W-1:0]   mag_q;

  assign mag  = num[DEN_W] ? (~num + 1'b1) : num;
  assign ge   = rem_r >= den_r;
  assign diff = ge ? (rem_r - den_r) : rem_r;
  assign rnd  = {1'b0, quo_r} + 1'b1;
  assign mag_q = rnd[Q_W:1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[DEN_W];
      den_nxt  = R_W'(den);
      rem_nxt  = mag;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below den, so the shift cannot overflow
      quo_nxt = {quo_r[Q_W-2:0], ge};
      rem_nxt = {diff[R_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign coef      = neg_r ? (~mag_q + 1'b1) : mag_q;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
